FILE: hdl/paq_pkg.sv
package paq_pkg;

  typedef enum logic [1:0] {
    CMD_ADMIT  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // latch the input beat and read the entry tables
    logic execute;  // apply the command and form the result
  } paq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
  } paq_stat_t;

endpackage

FILE: hdl/paq_in_if.sv
interface paq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] entry_id;
  logic [7:0] age;
  logic [1:0] level;

  modport source (output valid, cmd, entry_id, age, level, input ready);
  modport sink (input valid, cmd, entry_id, age, level, output ready);
endinterface

FILE: hdl/paq_out_if.sv
interface paq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] found_age;
  logic       any_waiting;
  logic [7:0] next_id;
  logic [1:0] next_level;

  modport source (output valid, status, found_age, any_waiting, next_id, next_level,
                  input ready);
  modport sink (input valid, status, found_age, any_waiting, next_id, next_level,
                output ready);
endinterface

FILE: hdl/paq_ram.sv
module paq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/paq_ctrl.sv
module paq_ctrl
  import paq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  paq_stat_t stat,
  output paq_cmd_t  ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready    = (state == S_IDLE) && !stat.busy;
  assign ctl.load    = in_valid && in_ready;
  assign ctl.execute = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (ctl.load) state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/paq_dp.sv
module paq_dp
  import paq_pkg::*;
#(
  parameter int ID_COUNT    = 256,
  parameter int LEVEL_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  paq_cmd_t   ctl,
  output paq_stat_t  stat,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_id,
  input  logic [7:0] in_age,
  input  logic [1:0] in_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_found_age,
  output logic       out_any,
  output logic [7:0] out_next_id,
  output logic [1:0] out_next_level
);

  localparam int IW = $clog2(ID_COUNT);
  localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int CW = IW + 1;

  // Latched beat.
  logic [1:0]    cmd_q;
  logic [IW-1:0] id_q;
  logic [7:0]    age_q;
  logic [LW-1:0] lvl_q;

  // Queue registers.
  logic [IW-1:0] head  [LEVEL_COUNT];
  logic [IW-1:0] tail  [LEVEL_COUNT];
  logic [CW-1:0] count [LEVEL_COUNT];

  logic [ID_COUNT-1:0] present;

  // Entry table read data (id addressed).
  logic [LW-1:0] rd_level;
  logic [7:0]    rd_age;
  logic [IW-1:0] rd_newer;
  logic [IW-1:0] rd_older;

  logic [IW-1:0] in_id_w;
  logic [LW-1:0] in_lvl_sat;
  assign in_id_w    = in_id[IW-1:0];
  assign in_lvl_sat = (32'(in_level) >= LEVEL_COUNT) ? LW'(LEVEL_COUNT - 1)
                                                      : LW'(in_level);

  // Write ports.
  logic          lvl_we, age_we;
  logic          nw_we, ol_we, nw2_we, ol2_we;
  logic [IW-1:0] nw_addr, nw_data, ol_addr, ol_data;

  paq_ram #(.WIDTH(LW), .DEPTH(ID_COUNT)) u_level (
    .clk, .we(lvl_we), .waddr(id_q), .wdata(lvl_q), .raddr(in_id_w), .rdata(rd_level)
  );
  paq_ram #(.WIDTH(8), .DEPTH(ID_COUNT)) u_age (
    .clk, .we(age_we), .waddr(id_q), .wdata(age_q), .raddr(in_id_w), .rdata(rd_age)
  );
  paq_ram #(.WIDTH(IW), .DEPTH(ID_COUNT)) u_newer (
    .clk, .we(nw_we), .waddr(nw_addr), .wdata(nw_data), .raddr(in_id_w), .rdata(rd_newer)
  );
  paq_ram #(.WIDTH(IW), .DEPTH(ID_COUNT)) u_older (
    .clk, .we(ol_we), .waddr(ol_addr), .wdata(ol_data), .raddr(in_id_w), .rdata(rd_older)
  );

  logic          pres;
  logic [LW-1:0] el;
  logic          is_head, is_tail;
  assign pres    = present[id_q];
  assign el      = rd_level;
  assign is_head = (head[el] == id_q);
  assign is_tail = (tail[el] == id_q);

  logic do_admit, do_remove;
  assign do_admit  = ctl.execute && (cmd_q == CMD_ADMIT) && !pres;
  assign do_remove = ctl.execute && (cmd_q == CMD_REMOVE) && pres
                     && (count[el] != '0);

  assign lvl_we = do_admit;
  assign age_we = do_admit;

  always_comb begin
    nw_we   = 1'b0;
    ol_we   = 1'b0;
    nw_addr = tail[lvl_q];
    nw_data = id_q;
    ol_addr = id_q;
    ol_data = tail[lvl_q];
    nw2_we  = 1'b0;
    ol2_we  = 1'b0;
    if (do_admit && count[lvl_q] != '0) begin
      nw_we = 1'b1;
      ol_we = 1'b1;
    end else if (do_remove) begin
      nw2_we  = !is_head;
      ol2_we  = !is_tail;
      nw_we   = nw2_we;
      nw_addr = rd_older;
      nw_data = rd_newer;
      ol_we   = ol2_we;
      ol_addr = rd_newer;
      ol_data = rd_older;
    end
  end

  // Post-step queue view for the result.
  logic [IW-1:0] head_n  [LEVEL_COUNT];
  logic [CW-1:0] count_n [LEVEL_COUNT];
  always_comb begin
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      head_n[l]  = head[l];
      count_n[l] = count[l];
    end
    if (do_admit) begin
      if (count[lvl_q] == '0) head_n[lvl_q] = id_q;
      count_n[lvl_q] = count[lvl_q] + CW'(1);
    end else if (do_remove) begin
      if (is_head) head_n[el] = rd_newer;
      count_n[el] = count[el] - CW'(1);
    end
  end

  logic          any_n;
  logic [IW-1:0] nid_n;
  logic [LW-1:0] nlv_n;
  always_comb begin
    any_n = 1'b0;
    nid_n = '0;
    nlv_n = '0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if (count_n[l] != '0) begin
        any_n = 1'b1;
        nid_n = head_n[l];
        nlv_n = LW'(l);
      end
    end
  end

  logic [1:0] st_n;
  logic [7:0] fa_n;
  always_comb begin
    st_n = ST_OK;
    fa_n = '0;
    unique case (cmd_q)
      CMD_ADMIT:  if (pres) st_n = ST_DUPLICATE;
      CMD_LOOKUP: if (pres) fa_n = rd_age; else st_n = ST_NOT_FOUND;
      CMD_REMOVE: if (!pres) st_n = ST_NOT_FOUND;
      default:    st_n = ST_OK;
    endcase
  end

  assign stat.busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= in_cmd;
      id_q  <= in_id_w;
      age_q <= in_age;
      lvl_q <= in_lvl_sat;
    end
    if (ctl.execute) begin
      out_status     <= st_n;
      out_found_age  <= fa_n;
      out_any        <= any_n;
      out_next_id    <= 8'(nid_n);
      out_next_level <= 2'(nlv_n);
      for (int l = 0; l < LEVEL_COUNT; l++) head[l] <= head_n[l];
      if (do_admit) tail[lvl_q] <= id_q;
      if (do_remove && is_tail) tail[el] <= rd_older;
    end
    if (rst) begin
      out_valid <= 1'b0;
      present   <= '0;
      for (int l = 0; l < LEVEL_COUNT; l++) count[l] <= '0;
    end else begin
      if (ctl.execute) begin
        out_valid <= 1'b1;
        for (int l = 0; l < LEVEL_COUNT; l++) count[l] <= count_n[l];
        if (do_admit) present[id_q] <= 1'b1;
        if (ctl.execute && cmd_q == CMD_REMOVE) present[id_q] <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/priority_admission_queue.sv
// Priority admission queue: strict-priority multilevel FIFO of entry ids with
// admit, lookup and constant-time remove. The entry tables (simple dual-port
// RAMs with registered read) are read as the beat is latched, and the
// linked-list update and result are formed in the execute state that follows.
// A new beat is taken when the controller is idle and the result register is
// free or being drained, so no command is accepted while another executes.
// Presence bits and queue counts clear at reset; no clearing pass is needed.
module priority_admission_queue
  import paq_pkg::*;
#(
  parameter int ID_COUNT    = 256,
  parameter int LEVEL_COUNT = 3
) (
  input logic clk,
  input logic rst,
  paq_in_if.sink    in_ch,
  paq_out_if.source out_ch
);

  paq_cmd_t  ctl;
  paq_stat_t stat;

  paq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat, .ctl
  );

  paq_dp #(.ID_COUNT(ID_COUNT), .LEVEL_COUNT(LEVEL_COUNT)) u_dp (
    .clk, .rst, .ctl, .stat,
    .in_cmd(in_ch.cmd),
    .in_id(in_ch.entry_id),
    .in_age(in_ch.age),
    .in_level(in_ch.level),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_status(out_ch.status),
    .out_found_age(out_ch.found_age),
    .out_any(out_ch.any_waiting),
    .out_next_id(out_ch.next_id),
    .out_next_level(out_ch.next_level)
  );

endmodule

FILE: hdl/paq_checker.sv
module paq_checker
  import paq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] found_age,
  input logic       any_waiting,
  input logic [7:0] next_id,
  input logic [1:0] next_level
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid) else $error("no result after beat");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("beat taken while busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_waiting |-> next_id == 8'd0 && next_level == 2'd0)
    else $error("empty result not zero");

  a_age_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> found_age == 8'd0) else $error("age on error");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(next_id))
    else $error("result dropped");

endmodule

bind priority_admission_queue paq_checker u_paq_checker (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .found_age(out_ch.found_age),
  .any_waiting(out_ch.any_waiting), .next_id(out_ch.next_id),
  .next_level(out_ch.next_level)
);

FILE: test/tb_paq_checker.sv
`timescale 1ns / 1ps

module tb_paq_checker
  import paq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  paq_in_if         in_ch,
  paq_out_if        out_ch,
  output int        mismatch_count,
  output int        pending_count
);

  typedef struct packed {
    status_t    status;
    logic [7:0] found_age;
    logic       any_waiting;
    logic [7:0] next_id;
    logic [1:0] next_level;
  } verdict_t;

  localparam int NUM_IDS    = 256;
  localparam int NUM_LEVELS = 3;

  logic       held    [NUM_IDS];
  logic [1:0] held_lvl[NUM_IDS];
  logic [7:0] held_age[NUM_IDS];
  logic [7:0] newer_of[NUM_IDS];
  logic [7:0] older_of[NUM_IDS];
  logic [7:0] lvl_head[NUM_LEVELS];
  logic [7:0] lvl_tail[NUM_LEVELS];
  int         lvl_size[NUM_LEVELS];

  verdict_t awaited[$];

  function automatic verdict_t admission_step(logic [1:0] op, logic [7:0] id,
                                              logic [7:0] age, logic [1:0] lvl);
    verdict_t v;
    logic [1:0] q;
    logic [7:0] o;
    logic [7:0] n;
    v = '0;
    v.status = ST_OK;
    case (cmd_t'(op))
      CMD_ADMIT: begin
        if (held[id]) begin
          v.status = ST_DUPLICATE;
        end else begin
          q = (lvl >= NUM_LEVELS) ? 2'(NUM_LEVELS - 1) : lvl;
          held[id] = 1'b1;
          held_lvl[id] = q;
          held_age[id] = age;
          if (lvl_size[q] == 0) begin
            lvl_head[q] = id;
          end else begin
            newer_of[lvl_tail[q]] = id;
            older_of[id] = lvl_tail[q];
          end
          lvl_tail[q] = id;
          lvl_size[q]++;
        end
      end
      CMD_LOOKUP: begin
        if (held[id]) v.found_age = held_age[id];
        else v.status = ST_NOT_FOUND;
      end
      CMD_REMOVE: begin
        if (held[id]) begin
          q = held_lvl[id];
          o = older_of[id];
          n = newer_of[id];
          if (lvl_size[q] != 0) begin
            if (lvl_head[q] == id) lvl_head[q] = n;
            else newer_of[o] = n;
            if (lvl_tail[q] == id) lvl_tail[q] = o;
            else older_of[n] = o;
            lvl_size[q]--;
          end
          held[id] = 1'b0;
        end else begin
          v.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (lvl_size[l] != 0) begin
        v.any_waiting = 1'b1;
        v.next_id = lvl_head[l];
        v.next_level = 2'(l);
        break;
      end
    end
    return v;
  endfunction

  assign pending_count = awaited.size();

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst) begin
      for (int i = 0; i < NUM_IDS; i++) begin
        held[i] = 1'b0; held_lvl[i] = '0; held_age[i] = '0;
        newer_of[i] = '0; older_of[i] = '0;
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
        lvl_head[l] = '0; lvl_tail[l] = '0; lvl_size[l] = 0;
      end
      awaited.delete();
      mismatch_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {status_t'(out_ch.status), out_ch.found_age, out_ch.any_waiting,
               out_ch.next_id, out_ch.next_level};
        if (awaited.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result beat %h", got);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("mismatch: status %0d/%0d age %0d/%0d any %0d/%0d id %0d/%0d lvl %0d/%0d",
                       want.status, got.status, want.found_age, got.found_age,
                       want.any_waiting, got.any_waiting, want.next_id, got.next_id,
                       want.next_level, got.next_level);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited.push_back(admission_step(in_ch.cmd, in_ch.entry_id, in_ch.age, in_ch.level));
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import paq_pkg::*;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   pending_count;
  int   cycle_count = 0;
  bit   calm;
  bit   hold_off;

  paq_in_if  in_ch();
  paq_out_if out_ch();

  priority_admission_queue u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  tb_paq_checker u_chk (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                        .mismatch_count(mismatch_count), .pending_count(pending_count));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  logic [7:0] live_ids[$];

  task automatic send_beat(logic [1:0] op, logic [7:0] id, logic [7:0] age, logic [1:0] lvl);
    while (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= op;
    in_ch.entry_id <= id;
    in_ch.age <= age;
    in_ch.level <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_beat();
    int r;
    logic [7:0] id;
    r = $urandom_range(99);
    id = (live_ids.size() != 0 && r < 60) ? live_ids[$urandom_range(live_ids.size() - 1)]
                                          : 8'($urandom_range(15) * 16 + $urandom_range(15));
    if (r % 3 == 0 || live_ids.size() < 4) begin
      send_beat(CMD_ADMIT, id, 8'($urandom), 2'($urandom_range(3)));
      live_ids.push_back(id);
    end else if (r % 3 == 1) begin
      send_beat(CMD_REMOVE, id, 8'($urandom), 2'($urandom));
      foreach (live_ids[i]) if (live_ids[i] == id) begin live_ids.delete(i); break; end
    end else if (r < 95) begin
      send_beat(CMD_LOOKUP, id, 8'($urandom), 2'($urandom));
    end else begin
      send_beat(CMD_NONE, id, 8'($urandom), 2'($urandom));
    end
  endtask

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    calm = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NONE;
    in_ch.entry_id = '0;
    in_ch.age = '0;
    in_ch.level = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    send_beat(CMD_LOOKUP, 8'd0, 8'd0, 2'd0);
    send_beat(CMD_REMOVE, 8'd255, 8'd0, 2'd0);
    send_beat(CMD_ADMIT, 8'd0, 8'd0, 2'd0);
    send_beat(CMD_ADMIT, 8'd255, 8'd255, 2'd3);
    send_beat(CMD_ADMIT, 8'd170, 8'd85, 2'd1);
    send_beat(CMD_ADMIT, 8'd85, 8'd170, 2'd2);
    send_beat(CMD_ADMIT, 8'd0, 8'd9, 2'd1);
    send_beat(CMD_LOOKUP, 8'd255, 8'd0, 2'd0);
    send_beat(CMD_LOOKUP, 8'd0, 8'd0, 2'd0);
    send_beat(CMD_NONE, 8'd170, 8'd255, 2'd3);
    send_beat(CMD_REMOVE, 8'd170, 8'd0, 2'd0);
    send_beat(CMD_REMOVE, 8'd255, 8'd0, 2'd0);
    send_beat(CMD_REMOVE, 8'd85, 8'd0, 2'd0);
    send_beat(CMD_LOOKUP, 8'd85, 8'd0, 2'd0);
    send_beat(CMD_REMOVE, 8'd0, 8'd0, 2'd0);
    send_beat(CMD_LOOKUP, 8'd0, 8'd0, 2'd0);
    repeat (200) random_beat();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (30) random_beat();
        in_ch.valid <= 1'b0;
      end
    join
    while (pending_count != 0) @(negedge clk);
    calm = 1'b1;
    repeat (150) random_beat();
    calm = 1'b0;
    repeat (300) random_beat();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
